// ===== rtl/epms_pkg.sv =====
// Package for the epoch-millisecond to packed-date converter: types, constants and microcode.
package epms_pkg;

  // Field widths and limits.
  localparam int unsigned MillisW  = 64;
  localparam int unsigned PackedW  = 38;
  localparam int unsigned YearW    = 12;
  localparam int unsigned SpanW    = 35;
  localparam int unsigned PcW      = 4;

  localparam logic [YearW-1:0] EpochYear = YearW'(1900);
  localparam logic [YearW-1:0] MaxYear   = YearW'(4095);

  // Spans in milliseconds that the walk takes off the running remainder.
  localparam logic [SpanW-1:0] MsPerSec      = SpanW'(64'd1000);
  localparam logic [SpanW-1:0] MsPerMin      = SpanW'(64'd60 * 64'd1000);
  localparam logic [SpanW-1:0] MsPerHour     = SpanW'(64'd3600 * 64'd1000);
  localparam logic [SpanW-1:0] MsPerDay      = SpanW'(64'd86400 * 64'd1000);
  localparam logic [SpanW-1:0] MsPerYear     = SpanW'(64'd365 * 64'd86400 * 64'd1000);
  localparam logic [SpanW-1:0] MsPerLeapYear = SpanW'(64'd366 * 64'd86400 * 64'd1000);
  localparam logic [SpanW-1:0] MsPer28Days   = SpanW'(64'd28 * 64'd86400 * 64'd1000);
  localparam logic [SpanW-1:0] MsPer29Days   = SpanW'(64'd29 * 64'd86400 * 64'd1000);
  localparam logic [SpanW-1:0] MsPer30Days   = SpanW'(64'd30 * 64'd86400 * 64'd1000);
  localparam logic [SpanW-1:0] MsPer31Days   = SpanW'(64'd31 * 64'd86400 * 64'd1000);

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_YEAR,
    OP_MONTH,
    OP_DAY,
    OP_HOUR,
    OP_MIN,
    OP_SEC,
    OP_EMIT,
    OP_EMIT_OVF
  } op_e;

  // Jump conditions; when the condition is false the step repeats, unless the year step takes its overflow exit.
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_YEAR_END,
    COND_MONTH_END,
    COND_UNIT_END,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PcW-1:0]   target;
    logic [PcW-1:0]   alt;
  } uword_t;

  // Step addresses of the program.
  localparam logic [PcW-1:0] S_IDLE  = 4'd0;
  localparam logic [PcW-1:0] S_YEAR  = 4'd1;
  localparam logic [PcW-1:0] S_MONTH = 4'd2;
  localparam logic [PcW-1:0] S_DAY   = 4'd3;
  localparam logic [PcW-1:0] S_HOUR  = 4'd4;
  localparam logic [PcW-1:0] S_MIN   = 4'd5;
  localparam logic [PcW-1:0] S_SEC   = 4'd6;
  localparam logic [PcW-1:0] S_EMIT  = 4'd7;
  localparam logic [PcW-1:0] S_OVF   = 4'd8;

  // Control store: one word per step.
  function automatic uword_t ucode_rom(input logic [PcW-1:0] addr);
    uword_t w;
    unique case (addr)
      S_IDLE:  w = '{OP_LOAD,     COND_IN_VALID,  S_YEAR,  S_IDLE};
      S_YEAR:  w = '{OP_YEAR,     COND_YEAR_END,  S_MONTH, S_OVF};
      S_MONTH: w = '{OP_MONTH,    COND_MONTH_END, S_DAY,   S_IDLE};
      S_DAY:   w = '{OP_DAY,      COND_UNIT_END,  S_HOUR,  S_IDLE};
      S_HOUR:  w = '{OP_HOUR,     COND_UNIT_END,  S_MIN,   S_IDLE};
      S_MIN:   w = '{OP_MIN,      COND_UNIT_END,  S_SEC,   S_IDLE};
      S_SEC:   w = '{OP_SEC,      COND_UNIT_END,  S_EMIT,  S_IDLE};
      S_EMIT:  w = '{OP_EMIT,     COND_OUT_FREE,  S_IDLE,  S_IDLE};
      S_OVF:   w = '{OP_EMIT_OVF, COND_OUT_FREE,  S_IDLE,  S_IDLE};
      default: w = '{OP_NOP,      COND_ALWAYS,    S_IDLE,  S_IDLE};
    endcase
    return w;
  endfunction

  // Length of a month in milliseconds (index 0 is January), February stretched in leap years.
  function automatic logic [SpanW-1:0] month_ms(input logic [3:0] mon, input logic leap);
    logic [SpanW-1:0] span;
    case (mon) inside
      4'd1:                    span = leap ? MsPer29Days : MsPer28Days;
      4'd3, 4'd5, 4'd8, 4'd10: span = MsPer30Days;
      default:                 span = MsPer31Days;
    endcase
    return span;
  endfunction

endpackage

// ===== rtl/epoch_ms_to_packed_date.sv =====
// Microcoded converter from epoch milliseconds to a packed calendar date word.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+--------------------------------------
//   in      | in_valid_i, in_ready_o | millis_i (64 bits)
//   out     | out_valid_o,out_ready_i| packed_date_o (38 bits), overflow_o
//
// Each step does one compare and subtract of a constant span on the millisecond remainder:
// one step per year passed since 1900 plus a closing one (up to 2196), then up to 12 month,
// 31 day, 24 hour, 60 minute and 60 second steps, plus the load and emit steps.
// A date past the last year stops the year walk and is flagged on overflow_o.
// Reset clears the step counter and the output valid flag; no clearing pass.
// The result sits in an output register, so a new beat is taken while it waits;
// the next result holds at its emit step until that register is free.
module epoch_ms_to_packed_date (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [epms_pkg::MillisW-1:0]  millis_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [epms_pkg::PackedW-1:0]  packed_date_o,
  output logic                          overflow_o
);
  import epms_pkg::*;

  logic [PcW-1:0]     pc_q, pc_d;
  logic [MillisW-1:0] rem_q, rem_d;
  logic [YearW-1:0]   year_q, year_d;
  logic [1:0]         mod4_q, mod4_d;
  logic [6:0]         mod100_q, mod100_d;
  logic [8:0]         mod400_q, mod400_d;
  logic [3:0]         mon_q, mon_d;
  logic [4:0]         day_q, day_d;
  logic [4:0]         hour_q, hour_d;
  logic [5:0]         min_q, min_d;
  logic [5:0]         sec_q, sec_d;
  logic               out_valid_q, out_valid_d;
  logic [PackedW-1:0] packed_q, packed_d;
  logic               ovf_q, ovf_d;

  uword_t           uw;
  logic             cond_ok;
  logic             ovf_jump;
  logic             leap;
  logic [SpanW-1:0] span;
  logic [MillisW:0] diff;
  logic             below;
  logic             month_end;
  logic             out_free;

  // Fetch the control word of the current step.
  assign uw = ucode_rom(pc_q);

  // Leap rule from the running year residues.
  assign leap = (mod4_q == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));

  // Span select and the shared subtractor; the borrow tells the remainder is below the span.
  always_comb begin
    case (uw.op)
      OP_YEAR:  span = leap ? MsPerLeapYear : MsPerYear;
      OP_MONTH: span = month_ms(mon_q, leap);
      OP_DAY:   span = MsPerDay;
      OP_HOUR:  span = MsPerHour;
      OP_MIN:   span = MsPerMin;
      default:  span = MsPerSec;
    endcase
  end
  assign diff      = {1'b0, rem_q} - {{(MillisW+1-SpanW){1'b0}}, span};
  assign below     = diff[MillisW];
  assign month_end = (mon_q == 4'd11) || below;
  assign out_free  = !out_valid_q || out_ready_i;

  // Branch condition of the current step.
  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:    cond_ok = 1'b1;
      COND_IN_VALID:  cond_ok = in_valid_i;
      COND_YEAR_END:  cond_ok = below;
      COND_MONTH_END: cond_ok = month_end;
      COND_UNIT_END:  cond_ok = below;
      COND_OUT_FREE:  cond_ok = out_free;
      default:        cond_ok = 1'b1;
    endcase
  end

  // The year step leaves through the alternate target when it would pass the last year.
  assign ovf_jump = (uw.op == OP_YEAR) && !below && (year_q == MaxYear);

  // Sequencer: take the alternate target on a year overflow, else jump on a true condition, otherwise repeat the step.
  always_comb begin
    if (ovf_jump) begin
      pc_d = uw.alt;
    end else if (cond_ok) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q;
    end
  end

  // Datapath driven by the operation field.
  always_comb begin
    rem_d       = rem_q;
    year_d      = year_q;
    mod4_d      = mod4_q;
    mod100_d    = mod100_q;
    mod400_d    = mod400_q;
    mon_d       = mon_q;
    day_d       = day_q;
    hour_d      = hour_q;
    min_d       = min_q;
    sec_d       = sec_q;
    packed_d    = packed_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (uw.op)
      OP_LOAD: begin
        if (in_valid_i) begin
          rem_d    = millis_i;
          year_d   = EpochYear;
          mod4_d   = 2'd0;
          mod100_d = 7'd0;
          mod400_d = 9'd300;
          mon_d    = 4'd0;
          day_d    = 5'd0;
          hour_d   = 5'd0;
          min_d    = 6'd0;
          sec_d    = 6'd0;
        end
      end
      OP_YEAR: begin
        if (!below && (year_q != MaxYear)) begin
          rem_d    = diff[MillisW-1:0];
          year_d   = year_q + YearW'(1);
          mod4_d   = mod4_q + 2'd1;
          mod100_d = (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
          mod400_d = (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
        end
      end
      OP_MONTH: begin
        if (!month_end) begin
          rem_d = diff[MillisW-1:0];
          mon_d = mon_q + 4'd1;
        end
      end
      OP_DAY: begin
        if (!below) begin
          rem_d = diff[MillisW-1:0];
          day_d = day_q + 5'd1;
        end
      end
      OP_HOUR: begin
        if (!below) begin
          rem_d  = diff[MillisW-1:0];
          hour_d = hour_q + 5'd1;
        end
      end
      OP_MIN: begin
        if (!below) begin
          rem_d = diff[MillisW-1:0];
          min_d = min_q + 6'd1;
        end
      end
      OP_SEC: begin
        if (!below) begin
          rem_d = diff[MillisW-1:0];
          sec_d = sec_q + 6'd1;
        end
      end
      OP_EMIT: begin
        if (out_free) begin
          packed_d    = {year_q, mon_q + 4'd1, day_q + 5'd1, hour_q, min_q, sec_q};
          ovf_d       = 1'b0;
          out_valid_d = 1'b1;
        end
      end
      OP_EMIT_OVF: begin
        if (out_free) begin
          packed_d    = '0;
          ovf_d       = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    year_q   <= year_d;
    mod4_q   <= mod4_d;
    mod100_q <= mod100_d;
    mod400_q <= mod400_d;
    mon_q    <= mon_d;
    day_q    <= day_d;
    hour_q   <= hour_d;
    min_q    <= min_d;
    sec_q    <= sec_d;
    packed_q <= packed_d;
    ovf_q    <= ovf_d;
  end

  assign in_ready_o    = (pc_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign packed_date_o = packed_q;
  assign overflow_o    = ovf_q;

endmodule
